@@ design/rts_pkg.sv @@
`default_nettype none

package rts_pkg;

  localparam int W = 32;
  localparam int DIV_BITS = 2;
  localparam int DIV_STAGES = W / DIV_BITS;

  typedef enum logic [1:0] {
    MODE_DOWN    = 2'd0,
    MODE_UP      = 2'd1,
    MODE_NEAREST = 2'd2
  } rts_mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_STEP = 2'd1,
    ST_OVERFLOW  = 2'd2
  } rts_status_t;

  typedef struct packed {
    logic [1:0]   mode;
    logic [W-1:0] value;
    logic [W-1:0] step;
  } rts_item_t;

  typedef struct packed {
    rts_item_t    item;
    logic [W-1:0] rem;
  } rts_div_t;

endpackage

`default_nettype wire

@@ design/rts_rem_pipe.sv @@
`default_nettype none

module rts_rem_pipe (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rts_pkg::rts_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rts_pkg::rts_div_t      out_data
);
  import rts_pkg::*;

  function automatic logic [W-1:0] rem_step(input logic [W-1:0] r, input logic b,
                                            input logic [W-1:0] s);
    logic [W:0] t;
    logic [W:0] d;
    t = {r, b};
    d = t - {1'b0, s};
    if (t >= {1'b0, s}) begin
      rem_step = d[W-1:0];
    end else begin
      rem_step = t[W-1:0];
    end
  endfunction

  logic [DIV_STAGES-1:0] vld_r;
  logic [DIV_STAGES-1:0] vld_in;
  logic [DIV_STAGES-1:0] rdy;
  rts_div_t              dat_r   [DIV_STAGES];
  rts_div_t              dat_src [DIV_STAGES];
  rts_div_t              dat_nxt [DIV_STAGES];

  always_comb begin
    rdy[DIV_STAGES-1] = !vld_r[DIV_STAGES-1] || out_ready;
    for (int i = DIV_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    localparam int HI = W - 1 - DIV_BITS * i;
    if (i == 0) begin : g_first
      assign vld_in[i]       = in_valid;
      assign dat_src[i].item = in_item;
      assign dat_src[i].rem  = '0;
    end else begin : g_rest
      assign vld_in[i]  = vld_r[i-1];
      assign dat_src[i] = dat_r[i-1];
    end

    always_comb begin
      logic [W-1:0] r1;
      r1 = rem_step(dat_src[i].rem, dat_src[i].item.value[HI], dat_src[i].item.step);
      dat_nxt[i].item = dat_src[i].item;
      dat_nxt[i].rem  = rem_step(r1, dat_src[i].item.value[HI-1], dat_src[i].item.step);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld_r[i] <= vld_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && vld_in[i]) begin
        dat_r[i] <= dat_nxt[i];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[DIV_STAGES-1];
  assign out_data  = dat_r[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ design/round_unsigned_to_step_top.sv @@
// Rounds an unsigned word to a multiple of a step: down, up to the next multiple, or nearest.
// The path is 16 remainder stages consuming two dividend bits each, then two
// stages that form the candidates and pick the result with its overflow check.
// Throughput is one word per cycle; a stalled output holds only the stages behind it.
// Synchronous active-low reset clears all valid bits; data registers are not reset.

`default_nettype none

module round_unsigned_to_step_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_value,
  input  wire logic [31:0] in_step,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_rounded,
  output logic [1:0]       out_status
);
  import rts_pkg::*;

  rts_item_t in_item;
  logic      div_valid;
  logic      div_ready;
  rts_div_t  div_data;

  assign in_item.mode  = in_req_type;
  assign in_item.value = in_value;
  assign in_item.step  = in_step;

  rts_rem_pipe u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  logic         a_vld_r;
  logic         a_zero_r;
  logic         a_up_r;
  logic [W-1:0] a_below_r;
  logic [W-1:0] a_gap_r;
  logic [W-1:0] a_value_r;
  logic         a_zero_nxt;
  logic         a_up_nxt;
  logic [W-1:0] a_below_nxt;
  logic [W-1:0] a_gap_nxt;
  logic         a_rdy;

  logic         o_vld_r;
  logic [W-1:0] o_rounded_r;
  rts_status_t  o_status_r;
  logic [W-1:0] o_rounded_nxt;
  rts_status_t  o_status_nxt;
  logic         o_rdy;

  assign o_rdy     = !o_vld_r || out_ready;
  assign a_rdy     = !a_vld_r || o_rdy;
  assign div_ready = a_rdy;

  always_comb begin
    a_zero_nxt  = (div_data.item.step == '0);
    a_below_nxt = div_data.item.value - div_data.rem;
    a_gap_nxt   = div_data.item.step - div_data.rem;
    case (div_data.item.mode)
      MODE_UP:      a_up_nxt = 1'b1;
      MODE_NEAREST: a_up_nxt = (div_data.rem >= a_gap_nxt);
      default:      a_up_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_rdy) begin
      a_vld_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && div_valid) begin
      a_zero_r  <= a_zero_nxt;
      a_up_r    <= a_up_nxt;
      a_below_r <= a_below_nxt;
      a_gap_r   <= a_gap_nxt;
      a_value_r <= div_data.item.value;
    end
  end

  always_comb begin
    logic [W:0] sum;
    sum = {1'b0, a_value_r} + {1'b0, a_gap_r};
    if (a_zero_r) begin
      o_rounded_nxt = '0;
      o_status_nxt  = ST_ZERO_STEP;
    end else if (!a_up_r) begin
      o_rounded_nxt = a_below_r;
      o_status_nxt  = ST_OK;
    end else if (sum[W]) begin
      o_rounded_nxt = '1;
      o_status_nxt  = ST_OVERFLOW;
    end else begin
      o_rounded_nxt = sum[W-1:0];
      o_status_nxt  = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (o_rdy) begin
      o_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && a_vld_r) begin
      o_rounded_r <= o_rounded_nxt;
      o_status_r  <= o_status_nxt;
    end
  end

  assign out_valid   = o_vld_r;
  assign out_rounded = o_rounded_r;
  assign out_status  = o_status_r;

endmodule

`default_nettype wire
